// ----- rtl/mbe_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// Used by the front end, the point queue, the iteration engine and the top level.
`default_nettype none

package mbe_pkg;

   localparam int WORD_BITS      = 32;
   localparam int WIDE_BITS      = 64;
   localparam int LIMIT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REAL_START = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAG_START = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REAL_STEP  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAG_STEP  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITER_LIMIT = 3'd4;

   localparam logic signed [WORD_BITS-1:0] RESET_REAL_START = -32'sd536870912;
   localparam logic signed [WORD_BITS-1:0] RESET_IMAG_START = -32'sd536870912;
   localparam logic signed [WORD_BITS-1:0] RESET_REAL_STEP  = 32'sd13421773;
   localparam logic signed [WORD_BITS-1:0] RESET_IMAG_STEP  = 32'sd26843546;
   localparam logic [LIMIT_BITS-1:0]       RESET_ITER_LIMIT = 16'd1000;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] real_start;
      logic signed [WORD_BITS-1:0] imag_start;
      logic signed [WORD_BITS-1:0] real_step;
      logic signed [WORD_BITS-1:0] imag_step;
   } map_cfg_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] re;
      logic signed [WORD_BITS-1:0] im;
   } point_type;

   localparam logic signed [WIDE_BITS-1:0] WORD_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [WIDE_BITS-1:0] WORD_MIN = -64'sh0000_0000_8000_0000;

   function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [WIDE_BITS-1:0] v);
      logic signed [WORD_BITS-1:0] r;
      if (v > WORD_MAX) begin
         r = WORD_MAX[WORD_BITS-1:0];
      end else if (v < WORD_MIN) begin
         r = WORD_MIN[WORD_BITS-1:0];
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_BITS-1:0] sext_word(
      input logic signed [WORD_BITS-1:0] v);
      return {{(WIDE_BITS-WORD_BITS){v[WORD_BITS-1]}}, v};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mbe_front.sv -----
// Front end: accepts pixel requests and maps them to the complex point c.
// Depends on mbe_pkg for the mapping configuration and point types.
`default_nettype none

module mbe_front
   import mbe_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire map_cfg_type           cfg,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [COORD_BITS-1:0] in_column,
   input  wire logic [COORD_BITS-1:0] in_row,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output point_type                  out_point
);

   localparam int PROD_W = COORD_BITS + 1 + WORD_BITS;

   logic                     valid_ff;
   logic signed [PROD_W-1:0] prod_re_ff;
   logic signed [PROD_W-1:0] prod_im_ff;
   logic signed [PROD_W-1:0] prod_re_in;
   logic signed [PROD_W-1:0] prod_im_in;
   logic signed [WIDE_BITS-1:0] sum_re;
   logic signed [WIDE_BITS-1:0] sum_im;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_comb begin
      prod_re_in = $signed({1'b0, in_column}) * cfg.real_step;
      prod_im_in = $signed({1'b0, in_row}) * cfg.imag_step;
      sum_re = sext_word(cfg.real_start)
             + {{(WIDE_BITS-PROD_W){prod_re_ff[PROD_W-1]}}, prod_re_ff};
      sum_im = sext_word(cfg.imag_start)
             + {{(WIDE_BITS-PROD_W){prod_im_ff[PROD_W-1]}}, prod_im_ff};
      out_point.re = sat_word(sum_re);
      out_point.im = sat_word(sum_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mbe_queue.sv -----
// Short queue of mapped points between the front end and the iteration engine.
// Depends on mbe_pkg for the point type and queue depth.
`default_nettype none

module mbe_queue
   import mbe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire point_type push_point,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output point_type      pop_point
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   point_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_point  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_point;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mbe_back.sv -----
// Iteration engine: runs z = z*z + c on one point until escape or the limit.
// Depends on mbe_pkg for the point type, saturation and sign extension.
`default_nettype none

module mbe_back
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS  = 28,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [LIMIT_BITS-1:0] limit,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire point_type             in_point,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [COUNT_BITS-1:0]      out_count,
   output logic                       out_inside
);

   localparam bit CAN_ESCAPE = (2 * FRAC_BITS + 2) < WIDE_BITS;
   localparam logic [WIDE_BITS-1:0] FOUR =
      CAN_ESCAPE ? (64'd4 << (2 * FRAC_BITS)) : 64'd0;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_SUM,
      S_UPD
   } state_type;

   state_type                   state_ff;
   point_type                   c_ff;
   point_type                   z_ff;
   point_type                   z_in;
   logic [LIMIT_BITS-1:0]       n_ff;
   logic signed [WIDE_BITS-1:0] rr_ff;
   logic signed [WIDE_BITS-1:0] ii_ff;
   logic signed [WIDE_BITS-1:0] ri_ff;
   logic [WIDE_BITS-1:0]        mag_ff;
   logic signed [WIDE_BITS-1:0] diff_ff;
   logic signed [WIDE_BITS-1:0] nr;
   logic signed [WIDE_BITS-1:0] ni;
   logic                        at_limit;
   logic                        escaped;
   logic                        out_fire;
   logic                        out_valid_ff;
   logic [COUNT_BITS-1:0]       out_count_ff;
   logic [COUNT_BITS-1:0]       count_in;
   logic                        out_inside_ff;

   assign in_ready   = (state_ff == S_IDLE);
   assign out_valid  = out_valid_ff;
   assign out_count  = out_count_ff;
   assign out_inside = out_inside_ff;

   generate
      if (COUNT_BITS <= LIMIT_BITS) begin : g_count_narrow
         assign count_in = n_ff[COUNT_BITS-1:0];
      end else begin : g_count_wide
         assign count_in = {{(COUNT_BITS-LIMIT_BITS){1'b0}}, n_ff};
      end
   endgenerate

   always_comb begin
      nr       = (diff_ff >>> FRAC_BITS) + sext_word(c_ff.re);
      ni       = (ri_ff >>> (FRAC_BITS - 1)) + sext_word(c_ff.im);
      z_in.re  = sat_word(nr);
      z_in.im  = sat_word(ni);
      at_limit = (n_ff == limit);
      escaped  = CAN_ESCAPE && (mag_ff > FOUR);
      out_fire = (state_ff == S_UPD) && (at_limit || escaped)
              && (!out_valid_ff || out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_fire) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  c_ff     <= in_point;
                  z_ff     <= in_point;
                  n_ff     <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               rr_ff    <= z_ff.re * z_ff.re;
               ii_ff    <= z_ff.im * z_ff.im;
               ri_ff    <= z_ff.re * z_ff.im;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               mag_ff   <= $unsigned(rr_ff) + $unsigned(ii_ff);
               diff_ff  <= rr_ff - ii_ff;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (at_limit || escaped) begin
                  if (out_fire) begin
                     out_count_ff  <= count_in;
                     out_inside_ff <= at_limit;
                     state_ff      <= S_IDLE;
                  end
               end else begin
                  z_ff     <= z_in;
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= S_MUL;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mandelbrot_escape_time_top.sv -----
// Mandelbrot escape-time block: configuration registers, front end, queue, engine.
// The single iteration engine takes a new point only once it is done with the last one;
// each iteration runs its multiply, sum and update steps in turn.
// The front end and a 4-entry queue take requests while the engine works.
// Reset (synchronous, active high) empties the pipeline and restores register defaults.
`default_nettype none

module mandelbrot_escape_time_top
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS  = 28,
   parameter int COORD_BITS = 10,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [WORD_BITS-1:0]      csr_wdata,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // pixel_column, pixel_row
   input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // iteration_count
   output logic [((COUNT_BITS+7)/8)*8-1:0] rsp_tdata,
   // inside_set
   output logic                           rsp_tuser
);

   localparam int RSP_W = ((COUNT_BITS + 7) / 8) * 8;

   map_cfg_type           cfg_ff;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  q_push_valid;
   logic                  q_push_ready;
   point_type             q_push_point;
   logic                  q_pop_valid;
   logic                  q_pop_ready;
   point_type             q_pop_point;
   logic [COUNT_BITS-1:0] count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_start <= RESET_REAL_START;
         cfg_ff.imag_start <= RESET_IMAG_START;
         cfg_ff.real_step  <= RESET_REAL_STEP;
         cfg_ff.imag_step  <= RESET_IMAG_STEP;
         limit_ff          <= RESET_ITER_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REAL_START: cfg_ff.real_start <= csr_wdata;
            CSR_IMAG_START: cfg_ff.imag_start <= csr_wdata;
            CSR_REAL_STEP:  cfg_ff.real_step  <= csr_wdata;
            CSR_IMAG_STEP:  cfg_ff.imag_step  <= csr_wdata;
            CSR_ITER_LIMIT: limit_ff          <= csr_wdata[LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   mbe_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_column (req_tdata[COORD_BITS-1:0]),
      .in_row    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .out_valid (q_push_valid),
      .out_ready (q_push_ready),
      .out_point (q_push_point)
   );

   mbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_point (q_push_point),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_point  (q_pop_point)
   );

   mbe_back #(
      .FRAC_BITS (FRAC_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .limit      (limit_ff),
      .in_valid   (q_pop_valid),
      .in_ready   (q_pop_ready),
      .in_point   (q_pop_point),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_count  (count),
      .out_inside (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(count);

endmodule

`default_nettype wire

// ----- dv/tb_mandelbrot_escape_time_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time_top: per-pixel iteration counts and
// in-set flags, predicted in Q4.28 arithmetic, checked against the response stream.
// Depends on mbe_pkg and the top-level RTL only.

module tb_mandelbrot_escape_time_top;
   import mbe_pkg::*;

   localparam int FRAC     = 28;
   localparam int COORD    = 10;
   localparam int COUNT    = 16;
   localparam int REQ_BITS = ((2*COORD+7)/8)*8;
   localparam int RSP_BITS = ((COUNT+7)/8)*8;
   localparam int COORD_MAX = (1 << COORD) - 1;

   localparam bit          ESCAPE_ON    = (2*FRAC + 2) < 64;
   localparam logic [63:0] ESCAPE_BOUND = ESCAPE_ON ? (64'd4 << (2*FRAC)) : 64'd0;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam int TIMEOUT_CYCLES = 5_000_000;
   localparam int HOLD_CYCLES    = 800;
   localparam int SETTLE_CYCLES  = 8;
   localparam int IDLE_PERCENT   = 35;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_PIXELS   = 75;

   typedef struct packed {
      logic [COORD-1:0] row;
      logic [COORD-1:0] col;
   } pixel_type;

   typedef struct packed {
      logic             in_set;
      logic [COUNT-1:0] count;
   } escape_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [WORD_BITS-1:0]      csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata  = '0;   // pixel_column, pixel_row
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;         // iteration_count
   logic                      rsp_tuser;         // inside_set

   logic signed [31:0]    view_real_start = -32'sd536870912;
   logic signed [31:0]    view_imag_start = -32'sd536870912;
   logic signed [31:0]    view_real_step  = 32'sd13421773;
   logic signed [31:0]    view_imag_step  = 32'sd26843546;
   logic [LIMIT_BITS-1:0] view_limit      = 16'd1000;

   pixel_type  pending_pixels[$];
   escape_type awaiting_escapes[$];

   int   mismatch_count = 0;
   int   cycle_count    = 0;
   bit   steady_flow    = 1'b0;
   bit   sink_hold_arm  = 1'b0;
   bit   hold_seen;
   int   sink_hold_left;

   mandelbrot_escape_time_top #(
      .FRAC_BITS  (FRAC),
      .COORD_BITS (COORD),
      .COUNT_BITS (COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic escape_type predict_escape(input pixel_type px);
      logic signed [31:0] cr, ci, zr, zi;
      longint             rr, ii, ri;
      logic [63:0]        mag;
      int unsigned        n;
      escape_type         r;
      cr = clamp_word(longint'(view_real_start) + longint'(px.col) * longint'(view_real_step));
      ci = clamp_word(longint'(view_imag_start) + longint'(px.row) * longint'(view_imag_step));
      zr = cr;
      zi = ci;
      n  = 0;
      while (n < view_limit) begin
         rr  = longint'(zr) * longint'(zr);
         ii  = longint'(zi) * longint'(zi);
         ri  = longint'(zr) * longint'(zi);
         mag = 64'(rr) + 64'(ii);
         if (ESCAPE_ON && mag > ESCAPE_BOUND) break;
         zr = clamp_word(((rr - ii) >>> FRAC) + longint'(cr));
         zi = clamp_word((ri >>> (FRAC - 1)) + longint'(ci));
         n++;
      end
      r.count  = n[COUNT-1:0];
      r.in_set = (n == view_limit);
      return r;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [WORD_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_REAL_START: view_real_start = data;
         CSR_IMAG_START: view_imag_start = data;
         CSR_REAL_STEP:  view_real_step  = data;
         CSR_IMAG_STEP:  view_imag_step  = data;
         CSR_ITER_LIMIT: view_limit      = data[LIMIT_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_view(input logic signed [31:0] re0, input logic signed [31:0] im0,
                            input logic signed [31:0] re_step,
                            input logic signed [31:0] im_step,
                            input logic [LIMIT_BITS-1:0] lim);
      write_csr(CSR_REAL_START, re0);
      write_csr(CSR_IMAG_START, im0);
      write_csr(CSR_REAL_STEP, re_step);
      write_csr(CSR_IMAG_STEP, im_step);
      // upper bits of the limit word are don't-care
      write_csr(CSR_ITER_LIMIT, {16'($urandom), lim});
      @(negedge clock);
   endtask

   task automatic queue_pixel(input int col, input int row);
      pixel_type px;
      px.col = col[COORD-1:0];
      px.row = row[COORD-1:0];
      pending_pixels.push_back(px);
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_tvalid || awaiting_escapes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      pixel_type px;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaiting_escapes.push_back(predict_escape(pixel_type'(req_tdata[2*COORD-1:0])));
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PERCENT)) begin
               px = pending_pixels.pop_front();
               req_tdata  <= {{(REQ_BITS-2*COORD){1'b0}}, px};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sink_hold_left <= 0;
         hold_seen      <= 1'b0;
      end else begin
         hold_seen <= sink_hold_arm;
         if (sink_hold_arm != hold_seen) begin
            sink_hold_left <= HOLD_CYCLES;
         end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      escape_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.count  = rsp_tdata[COUNT-1:0];
            got.in_set = rsp_tuser;
            if (awaiting_escapes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("cycle %0d: unexpected response count %0d inside %0b",
                           cycle_count, got.count, got.in_set);
            end else begin
               want = awaiting_escapes.pop_front();
               if (got.count !== want.count || got.in_set !== want.in_set) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("cycle %0d: count exp %0d got %0d, inside exp %0b got %0b",
                              cycle_count, want.count, got.count, want.in_set, got.in_set);
               end
            end
         end
         rsp_tready <= (sink_hold_left == 0) &&
                       (steady_flow || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic signed [31:0]    re0, im0, re_step, im_step;
      logic [LIMIT_BITS-1:0] lim;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // unmapped indexes must leave the reset view intact
      write_csr(CSR_SPARE_FIRST, $urandom);
      write_csr(CSR_SPARE_LAST, $urandom);
      @(negedge clock);
      queue_pixel(0, 0);
      queue_pixel(40, 20);
      queue_pixel(20, 20);
      queue_pixel(COORD_MAX, COORD_MAX);
      queue_pixel(0, COORD_MAX);
      wait_idle();

      // saturating corner mapping, single iteration
      load_view(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1);
      queue_pixel(0, 0);
      queue_pixel(COORD_MAX, COORD_MAX);
      queue_pixel(COORD_MAX, 0);
      queue_pixel(0, COORD_MAX);
      wait_idle();

      // zero limit: nothing iterates, flag still set
      load_view(32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'd0);
      queue_pixel(0, 0);
      queue_pixel(COORD_MAX, COORD_MAX);
      wait_idle();

      load_view(-32'sd536870912, -32'sd536870912, 32'sd13421773, 32'sd26843546, 16'hFFFF);
      queue_pixel(40, 20);
      queue_pixel(0, 0);
      queue_pixel(10, 10);
      queue_pixel(60, 30);
      wait_idle();

      // c = -2 sits exactly on the |z|^2 = 4 boundary
      load_view(-32'sd536870912, 32'sd0, 32'sd0, 32'sd1, 16'd3);
      queue_pixel(0, 0);
      queue_pixel(0, 1);
      queue_pixel(COORD_MAX, 0);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin
               re0     = -32'sd671088640 + $urandom_range(0, 1 << 27);
               im0     = -32'sd402653184 + $urandom_range(0, 1 << 27);
               re_step = $urandom_range(1 << 18, 3 << 18);
               im_step = $urandom_range(1 << 18, 3 << 18);
            end
            1: begin
               re0     = 32'sd268435456 - $urandom_range(0, 1 << 27);
               im0     = 32'sd402653184 - $urandom_range(0, 1 << 27);
               re_step = -$urandom_range(1 << 18, 3 << 18);
               im_step = -$urandom_range(1 << 18, 3 << 18);
            end
            2: begin
               re0     = $urandom;
               im0     = $urandom;
               re_step = $urandom;
               im_step = $urandom;
            end
            default: begin
               re0     = -32'sd201326592 + $urandom_range(0, 1 << 22);
               im0     = 32'sd26843546 + $urandom_range(0, 1 << 22);
               re_step = $urandom_range(1) ? $urandom_range(1, 4096) : -$urandom_range(1, 4096);
               im_step = $urandom_range(1) ? $urandom_range(1, 4096) : -$urandom_range(1, 4096);
            end
         endcase
         if (p == 5)
            lim = $urandom_range(200, 400);
         else if (p == 0)
            lim = $urandom_range(1, 16);
         else
            lim = $urandom_range(1, 48);
         load_view(re0, im0, re_step, im_step, lim);
         steady_flow = (p == 1);
         for (int i = 0; i < PHASE_PIXELS; i++)
            queue_pixel($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
         // back up the engine with the response side blocked
         if (p == 4) sink_hold_arm = ~sink_hold_arm;
         wait_idle();
      end
      steady_flow = 1'b0;

      wait_idle();
      if (mismatch_count == 0 && awaiting_escapes.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mbe_pkg.sv
rtl/mbe_front.sv
rtl/mbe_queue.sv
rtl/mbe_back.sv
rtl/mandelbrot_escape_time_top.sv
dv/tb_mandelbrot_escape_time_top.sv
